[sv/hc2_pkg.sv]
// ----------------------------------------------------------------------------
// hc2_pkg: shared types, constants and helpers for the 2x2 Hill stream cipher
// Holds the key matrix types, result slot type, register map and mod-26 math.
// ----------------------------------------------------------------------------
package hc2_pkg;

  localparam int unsigned AddrWidth = 5;
  localparam int unsigned DataWidth = 32;

  // Latency of the inverse-key derivation pipeline, in cycles
  localparam int unsigned DeriveLatency = 6;
  localparam int unsigned BusyWidth     = $clog2(DeriveLatency + 1);

  localparam logic [4:0]  Modulus     = 5'd26;
  localparam logic [10:0] DetBias     = 11'd676;   // 26*26 keeps the det sum positive
  localparam logic [19:0] Mod26Recip  = 20'd315;   // floor(2^13 / 26)
  localparam int unsigned Mod26Shift  = 13;
  localparam logic [4:0]  LetterX     = 5'd23;

  localparam logic [7:0] CharUpperA = 8'h41;
  localparam logic [7:0] CharUpperZ = 8'h5a;
  localparam logic [7:0] CharLowerA = 8'h61;
  localparam logic [7:0] CharLowerZ = 8'h7a;

  typedef enum logic [2:0] {
    RegKeyA = 3'd0,
    RegKeyB = 3'd1,
    RegKeyC = 3'd2,
    RegKeyD = 3'd3,
    RegMode = 3'd4
  } reg_idx_e;

  // Element [0] = a, [1] = b, [2] = c, [3] = d
  typedef logic [3:0][4:0] mat_t;

  localparam mat_t IdentMat = {5'd1, 5'd0, 5'd0, 5'd1};

  typedef struct packed {
    mat_t km;          // key reduced mod 26
    mat_t ik;          // inverse key, zero when not invertible
    logic invertible;
  } key_mat_t;

  typedef struct packed {
    logic [4:0] letter;
    logic       valid;
    logic       last;
    logic       odd;
    logic       nki;
  } res_t;

  // x mod 26 for x < 2048: reciprocal estimate, then one correction step
  function automatic logic [4:0] mod26(input logic [10:0] x);
    logic [19:0] prod;
    logic [11:0] rem;
    prod = 20'(x) * Mod26Recip;
    rem  = 12'(x) - 12'(prod[19:Mod26Shift]) * 12'(Modulus);
    if (rem >= 12'(Modulus)) begin
      rem = rem - 12'(Modulus);
    end
    return rem[4:0];
  endfunction

  // Multiplicative inverse mod 26, zero when none exists
  function automatic logic [4:0] inv26(input logic [4:0] det);
    logic [4:0] inv;
    case (det)
      5'd1:    inv = 5'd1;
      5'd3:    inv = 5'd9;
      5'd5:    inv = 5'd21;
      5'd7:    inv = 5'd15;
      5'd9:    inv = 5'd3;
      5'd11:   inv = 5'd19;
      5'd15:   inv = 5'd7;
      5'd17:   inv = 5'd23;
      5'd19:   inv = 5'd11;
      5'd21:   inv = 5'd5;
      5'd23:   inv = 5'd17;
      5'd25:   inv = 5'd25;
      default: inv = 5'd0;
    endcase
    return inv;
  endfunction

  function automatic res_t mk_res(input logic [4:0] letter, input logic valid,
                                  input logic odd, input logic nki);
    res_t r;
    r.letter = letter;
    r.valid  = valid;
    r.last   = 1'b0;
    r.odd    = odd;
    r.nki    = nki;
    return r;
  endfunction

endpackage

[sv/hc2_keygen.sv]
// ----------------------------------------------------------------------------
// hc2_keygen: key reduction and inverse-key derivation
// Pipelines det, det^-1 and adjugate products mod 26 after every key write.
// ----------------------------------------------------------------------------
module hc2_keygen
  import hc2_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mat_t     key_i,
  input  logic     key_we_i,
  output key_mat_t keys_o,
  output logic     busy_o
);

  mat_t                km_q, km_d;
  logic [10:0]         sum_q, sum_d;
  logic [4:0]          det_q;
  logic [4:0]          inv_q;
  logic [3:0][9:0]     prod_q, prod_d;
  logic                prod_ok_q;
  mat_t                ik_q, ik_d;
  logic                inv_ok_q;
  logic [BusyWidth-1:0] busy_q;
  logic [4:0]          neg_b, neg_c;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      km_d[i] = (key_i[i] >= Modulus) ? key_i[i] - Modulus : key_i[i];
    end
  end

  assign sum_d = 11'(10'(km_q[0]) * 10'(km_q[3])) + DetBias
               - 11'(10'(km_q[1]) * 10'(km_q[2]));

  assign neg_b = (km_q[1] == 5'd0) ? 5'd0 : Modulus - km_q[1];
  assign neg_c = (km_q[2] == 5'd0) ? 5'd0 : Modulus - km_q[2];

  assign prod_d[0] = 10'(inv_q) * 10'(km_q[3]);
  assign prod_d[1] = 10'(inv_q) * 10'(neg_b);
  assign prod_d[2] = 10'(inv_q) * 10'(neg_c);
  assign prod_d[3] = 10'(inv_q) * 10'(km_q[0]);

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      ik_d[i] = mod26({1'b0, prod_q[i]});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      km_q      <= IdentMat;
      sum_q     <= 11'd677;
      det_q     <= 5'd1;
      inv_q     <= 5'd1;
      prod_q    <= {10'd1, 10'd0, 10'd0, 10'd1};
      prod_ok_q <= 1'b1;
      ik_q      <= IdentMat;
      inv_ok_q  <= 1'b1;
      busy_q    <= '0;
    end else begin
      km_q      <= km_d;
      sum_q     <= sum_d;
      det_q     <= mod26(sum_q);
      inv_q     <= inv26(det_q);
      prod_q    <= prod_d;
      prod_ok_q <= (inv_q != 5'd0);
      ik_q      <= ik_d;
      inv_ok_q  <= prod_ok_q;
      if (key_we_i) begin
        busy_q <= BusyWidth'(DeriveLatency);
      end else if (busy_q != '0) begin
        busy_q <= busy_q - 1'b1;
      end
    end
  end

  assign keys_o.km         = km_q;
  assign keys_o.ik         = ik_q;
  assign keys_o.invertible = inv_ok_q;
  assign busy_o            = (busy_q != '0);

endmodule

[sv/hill_cipher_2x2_stream.sv]
// Flow: an accepted byte is registered in the input register, then its results are
// loaded into the result buffer once it is free. Throughput: one input byte per cycle
// while the buffer is free; a byte's results hold the buffer until the last is taken,
// so the output port sets the sustained rate. After a key write the input is held off
// while the inverse key settles. Reset (rst_ni, async, active low): identity key,
// encrypt mode, no held letter, no pending letter, buffers empty.
// ----------------------------------------------------------------------------
// hill_cipher_2x2_stream: streaming 2x2 Hill cipher mod 26 over ASCII bytes
// Input register, one pass of pairing/matrix logic, and a 3-entry result buffer.
// ----------------------------------------------------------------------------
module hill_cipher_2x2_stream
  import hc2_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // APB configuration
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [DataWidth-1:0] pwdata,
  output logic [DataWidth-1:0] prdata,
  output logic                 pready,
  // input stream
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           in_char_i,
  input  logic                 in_last_i,
  // result stream
  output logic                 res_valid_o,
  input  logic                 res_ready_i,
  output logic [7:0]           out_char_o,
  output logic                 out_valid_o,
  output logic                 out_last_o,
  output logic                 odd_length_error_o,
  output logic                 key_not_invertible_o
);

  mat_t       key_q;
  logic       mode_q;
  logic       wr_en, key_we;
  reg_idx_e   reg_idx;
  key_mat_t   keys;
  logic       key_busy;

  logic       s1_valid_q;
  logic [7:0] s1_char_q;
  logic       s1_last_q;
  logic       s1_adv;

  logic [4:0] held_q, held_d;
  logic       held_v_q, held_v_d;
  logic [4:0] pend_q, pend_d;
  logic       pend_v_q, pend_v_d;

  res_t       grp_q [3];
  res_t       slot_d [3];
  logic [1:0] n_d;
  logic [1:0] cnt_q;
  logic [1:0] head_q;
  logic       pop, grp_free;
  res_t       cur;

  logic       is_upper, is_lower, is_letter;
  logic [4:0] v;
  mat_t       mat;
  logic [4:0] pa, pb;
  logic [4:0] r0, r1;
  logic       nki;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = reg_idx_e'(paddr[AddrWidth-1:2]);
  assign key_we  = wr_en && (reg_idx == RegKeyA || reg_idx == RegKeyB ||
                             reg_idx == RegKeyC || reg_idx == RegKeyD);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q  <= IdentMat;
      mode_q <= 1'b0;
    end else if (wr_en) begin
      case (reg_idx)
        RegKeyA: key_q[0] <= pwdata[4:0];
        RegKeyB: key_q[1] <= pwdata[4:0];
        RegKeyC: key_q[2] <= pwdata[4:0];
        RegKeyD: key_q[3] <= pwdata[4:0];
        RegMode: mode_q   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegKeyA: prdata = DataWidth'(key_q[0]);
      RegKeyB: prdata = DataWidth'(key_q[1]);
      RegKeyC: prdata = DataWidth'(key_q[2]);
      RegKeyD: prdata = DataWidth'(key_q[3]);
      RegMode: prdata = DataWidth'(mode_q);
      default: prdata = '0;
    endcase
  end

  hc2_keygen u_keygen (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .key_i    (key_q),
    .key_we_i (key_we),
    .keys_o   (keys),
    .busy_o   (key_busy)
  );

  // --------------------------------------------------------------------------
  // Input register
  // --------------------------------------------------------------------------
  assign pop        = res_valid_o & res_ready_i;
  assign grp_free   = (cnt_q == 2'd0) || (cnt_q == 2'd1 && pop);
  assign s1_adv     = s1_valid_q & grp_free;
  assign in_ready_o = !key_busy && (!s1_valid_q || s1_adv);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_char_q <= in_char_i;
      s1_last_q <= in_last_i;
    end
  end

  // --------------------------------------------------------------------------
  // Letter decode and pair arithmetic
  // --------------------------------------------------------------------------
  assign is_upper  = s1_char_q inside {[CharUpperA:CharUpperZ]};
  assign is_lower  = s1_char_q inside {[CharLowerA:CharLowerZ]};
  assign is_letter = is_upper | is_lower;
  assign v         = is_upper ? 5'(s1_char_q - CharUpperA) : 5'(s1_char_q - CharLowerA);

  assign mat = mode_q ? keys.ik : keys.km;
  // Pair is (held, current) when completing one, else (odd letter, X) for padding
  assign pa  = held_v_q ? held_q : v;
  assign pb  = (is_letter && held_v_q) ? v : LetterX;
  assign r0  = mod26(11'(10'(mat[0]) * 10'(pa)) + 11'(10'(mat[1]) * 10'(pb)));
  assign r1  = mod26(11'(10'(mat[2]) * 10'(pa)) + 11'(10'(mat[3]) * 10'(pb)));
  assign nki = mode_q & ~keys.invertible;

  always_comb begin
    slot_d   = '{default: '0};
    n_d      = 2'd0;
    held_d   = held_q;
    held_v_d = held_v_q;
    pend_d   = pend_q;
    pend_v_d = pend_v_q;

    if (!mode_q) begin
      if (is_letter) begin
        if (pend_v_d) begin
          slot_d[n_d] = mk_res(pend_d, 1'b1, 1'b0, 1'b0);
          n_d         = n_d + 2'd1;
          pend_v_d    = 1'b0;
        end
        if (held_v_d) begin
          slot_d[n_d] = mk_res(r0, 1'b1, 1'b0, 1'b0);
          n_d         = n_d + 2'd1;
          slot_d[n_d] = mk_res(r1, 1'b1, 1'b0, 1'b0);
          n_d         = n_d + 2'd1;
          held_v_d    = 1'b0;
        end else begin
          held_d   = v;
          held_v_d = 1'b1;
        end
      end
      if (s1_last_q) begin
        if (pend_v_d) begin
          slot_d[n_d] = mk_res(pend_d, 1'b1, 1'b0, 1'b0);
          n_d         = n_d + 2'd1;
        end
        // pad the odd letter with X
        if (held_v_d) begin
          slot_d[n_d] = mk_res(r0, 1'b1, 1'b0, 1'b0);
          n_d         = n_d + 2'd1;
          slot_d[n_d] = mk_res(r1, 1'b1, 1'b0, 1'b0);
          n_d         = n_d + 2'd1;
        end
      end
    end else if (!keys.invertible) begin
      // pass letters through, flushing pending then held first
      if (is_letter || s1_last_q) begin
        if (pend_v_d) begin
          slot_d[n_d] = mk_res(pend_d, 1'b1, 1'b0, 1'b1);
          n_d         = n_d + 2'd1;
        end
        if (held_v_d) begin
          slot_d[n_d] = mk_res(held_d, 1'b1, 1'b0, 1'b1);
          n_d         = n_d + 2'd1;
        end
        pend_v_d = 1'b0;
        held_v_d = 1'b0;
        if (is_letter) begin
          slot_d[n_d] = mk_res(v, 1'b1, 1'b0, 1'b1);
          n_d         = n_d + 2'd1;
        end
      end
    end else begin
      if (is_letter) begin
        if (held_v_d) begin
          if (pend_v_d) begin
            slot_d[n_d] = mk_res(pend_d, 1'b1, 1'b0, 1'b0);
            n_d         = n_d + 2'd1;
          end
          slot_d[n_d] = mk_res(r0, 1'b1, 1'b0, 1'b0);
          n_d         = n_d + 2'd1;
          // hold back the second plaintext letter in case it is trailing padding
          pend_d      = r1;
          pend_v_d    = 1'b1;
          held_v_d    = 1'b0;
        end else begin
          held_d   = v;
          held_v_d = 1'b1;
        end
      end
      if (s1_last_q) begin
        if (held_v_d) begin
          if (pend_v_d) begin
            slot_d[n_d] = mk_res(pend_d, 1'b1, 1'b0, 1'b0);
            n_d         = n_d + 2'd1;
          end
          slot_d[n_d] = mk_res(held_d, 1'b1, 1'b1, 1'b0);
          n_d         = n_d + 2'd1;
        end else if (pend_v_d && pend_d != LetterX) begin
          slot_d[n_d] = mk_res(pend_d, 1'b1, 1'b0, 1'b0);
          n_d         = n_d + 2'd1;
        end
      end
    end

    if (s1_last_q) begin
      if (n_d == 2'd0) begin
        slot_d[n_d] = mk_res(5'd0, 1'b0, 1'b0, nki);
        n_d         = n_d + 2'd1;
      end
      slot_d[n_d - 2'd1].last = 1'b1;
      held_d   = 5'd0;
      held_v_d = 1'b0;
      pend_d   = 5'd0;
      pend_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q   <= 5'd0;
      held_v_q <= 1'b0;
      pend_q   <= 5'd0;
      pend_v_q <= 1'b0;
    end else if (s1_adv) begin
      held_q   <= held_d;
      held_v_q <= held_v_d;
      pend_q   <= pend_d;
      pend_v_q <= pend_v_d;
    end
  end

  // --------------------------------------------------------------------------
  // Result buffer: drains one entry per output transaction
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= 2'd0;
      head_q <= 2'd0;
    end else if (s1_adv) begin
      cnt_q  <= n_d;
      head_q <= 2'd0;
    end else if (pop) begin
      cnt_q  <= cnt_q - 2'd1;
      head_q <= head_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      grp_q <= slot_d;
    end
  end

  assign cur                  = grp_q[head_q];
  assign res_valid_o          = (cnt_q != 2'd0);
  assign out_char_o           = cur.valid ? CharUpperA + 8'(cur.letter) : 8'd0;
  assign out_valid_o          = cur.valid;
  assign out_last_o           = cur.last;
  assign odd_length_error_o   = cur.odd;
  assign key_not_invertible_o = cur.nki;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_last_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && s1_last_q |=> cnt_q != 2'd0)
    else $error("message end produced no result");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && s1_last_q |=> !held_v_q && !pend_v_q)
    else $error("held or pending letter survived message end");

  a_last_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && out_last_o |-> cnt_q == 2'd1)
    else $error("last flag not on final buffered result");

  a_odd_letter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && odd_length_error_o |-> out_valid_o && !key_not_invertible_o)
    else $error("odd-length flag on a non-letter or non-invertible result");

  a_derive_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_we |=> !in_ready_o)
    else $error("input accepted while inverse key is being derived");

endmodule

[sim/tb_hill_cipher_2x2_stream.sv]
// ----------------------------------------------------------------------------
// tb_hill_cipher_2x2_stream: self-checking bench for the 2x2 Hill stream cipher
// Feeds byte messages in both directions under a range of keys and compares
// every result field against an in-bench mod-26 predictor, with random idle
// gaps on the input side and random stalls on the result side.
// ----------------------------------------------------------------------------
module tb_hill_cipher_2x2_stream;
  import hc2_pkg::*;

  localparam logic [4:0] X_LETTER = 5'd23;
  localparam reg_idx_e KEY_REGS [4] = '{RegKeyA, RegKeyB, RegKeyC, RegKeyD};

  typedef struct packed {
    logic [7:0] ch;
    logic       vld;
    logic       lst;
    logic       odd;
    logic       nki;
  } cipher_res_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       lst;
    logic [7:0] gap;
  } byte_item_t;

  logic                 clk_i   = 1'b0;
  logic                 rst_ni  = 1'b0;
  logic                 psel    = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite  = 1'b0;
  logic [AddrWidth-1:0] paddr   = '0;
  logic [DataWidth-1:0] pwdata  = '0;
  logic [DataWidth-1:0] prdata;
  logic                 pready;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  logic [7:0]           in_char_i   = '0;
  logic                 in_last_i   = 1'b0;
  logic                 res_valid_o;
  logic                 res_ready_i = 1'b0;
  logic [7:0]           out_char_o;
  logic                 out_valid_o;
  logic                 out_last_o;
  logic                 odd_length_error_o;
  logic                 key_not_invertible_o;

  hill_cipher_2x2_stream dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .in_char_i           (in_char_i),
    .in_last_i           (in_last_i),
    .res_valid_o         (res_valid_o),
    .res_ready_i         (res_ready_i),
    .out_char_o          (out_char_o),
    .out_valid_o         (out_valid_o),
    .out_last_o          (out_last_o),
    .odd_length_error_o  (odd_length_error_o),
    .key_not_invertible_o(key_not_invertible_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Predictor state
  logic [4:0]  key_m [4];
  logic [4:0]  inv_m [4];
  logic        inv_ok;
  logic        dec_mode;
  logic [4:0]  held_l, pend_l;
  logic        held_v, pend_v;
  cipher_res_t step_buf [3];
  int          step_n;

  cipher_res_t cipher_out_q [$];
  byte_item_t  in_bytes_q [$];
  byte_item_t  drv_item;
  cipher_res_t mon_want;
  int          gap_cnt      = 0;
  int          stall_cnt    = 0;
  int          mismatch_cnt = 0;
  int          sent_cnt     = 0;
  bit          idling       = 1'b0;

  function automatic logic [4:0] mac26(input logic [4:0] m0, input logic [4:0] x0,
                                       input logic [4:0] m1, input logic [4:0] x1);
    return 5'((int'(m0) * int'(x0) + int'(m1) * int'(x1)) % 26);
  endfunction

  function automatic void derive_inverse();
    int det;
    int inv;
    det = (int'(key_m[0]) * int'(key_m[3]) + 676 - int'(key_m[1]) * int'(key_m[2])) % 26;
    inv = 0;
    for (int x = 1; x < 26; x++) begin
      if (inv == 0 && (det * x) % 26 == 1) inv = x;
    end
    inv_ok = (inv != 0);
    if (!inv_ok) begin
      for (int i = 0; i < 4; i++) inv_m[i] = '0;
    end else begin
      inv_m[0] = 5'((inv * int'(key_m[3])) % 26);
      inv_m[1] = 5'((inv * ((26 - int'(key_m[1])) % 26)) % 26);
      inv_m[2] = 5'((inv * ((26 - int'(key_m[2])) % 26)) % 26);
      inv_m[3] = 5'((inv * int'(key_m[0])) % 26);
    end
  endfunction

  function automatic void reset_model();
    key_m[0] = 5'd1;
    key_m[1] = 5'd0;
    key_m[2] = 5'd0;
    key_m[3] = 5'd1;
    dec_mode = 1'b0;
    held_l = '0;
    held_v = 1'b0;
    pend_l = '0;
    pend_v = 1'b0;
    derive_inverse();
  endfunction

  function automatic void apply_cfg(input reg_idx_e idx, input logic [4:0] val);
    case (idx)
      RegKeyA: key_m[0] = 5'(val % 26);
      RegKeyB: key_m[1] = 5'(val % 26);
      RegKeyC: key_m[2] = 5'(val % 26);
      RegKeyD: key_m[3] = 5'(val % 26);
      RegMode: dec_mode = val[0];
      default: ;
    endcase
    if (idx != RegMode) derive_inverse();
  endfunction

  function automatic void encipher(input logic [4:0] p0, input logic [4:0] p1,
                                   output logic [4:0] c0, output logic [4:0] c1);
    c0 = mac26(key_m[0], p0, key_m[1], p1);
    c1 = mac26(key_m[2], p0, key_m[3], p1);
  endfunction

  function automatic void emit_res(input logic [4:0] letter, input logic vld,
                                   input logic odd, input logic nki);
    step_buf[step_n].ch  = vld ? 8'h41 + 8'(letter) : 8'h00;
    step_buf[step_n].vld = vld;
    step_buf[step_n].lst = 1'b0;
    step_buf[step_n].odd = odd;
    step_buf[step_n].nki = nki;
    step_n++;
  endfunction

  function automatic bit is_letter_byte(input logic [7:0] ch);
    return (ch >= 8'h41 && ch <= 8'h5a) || (ch >= 8'h61 && ch <= 8'h7a);
  endfunction

  // Work out the results that one accepted byte causes and queue them
  function automatic void hill_predict_byte(input logic [7:0] ch, input logic lst);
    logic       is_let;
    logic [4:0] v, p0, p1, c0, c1;
    logic       nki;
    step_n = 0;
    nki    = dec_mode && !inv_ok;
    is_let = is_letter_byte(ch);
    v      = (ch >= 8'h61) ? 5'(ch - 8'h61) : 5'(ch - 8'h41);
    if (!dec_mode) begin
      if (is_let) begin
        if (pend_v) begin
          emit_res(pend_l, 1'b1, 1'b0, 1'b0);
          pend_v = 1'b0;
        end
        if (held_v) begin
          encipher(held_l, v, c0, c1);
          emit_res(c0, 1'b1, 1'b0, 1'b0);
          emit_res(c1, 1'b1, 1'b0, 1'b0);
          held_v = 1'b0;
        end else begin
          held_l = v;
          held_v = 1'b1;
        end
      end
      if (lst) begin
        if (pend_v) emit_res(pend_l, 1'b1, 1'b0, 1'b0);
        if (held_v) begin
          // pad the odd letter with X
          encipher(held_l, X_LETTER, c0, c1);
          emit_res(c0, 1'b1, 1'b0, 1'b0);
          emit_res(c1, 1'b1, 1'b0, 1'b0);
        end
      end
    end else if (!inv_ok) begin
      // flush pending, then held, then pass the letter through
      if (is_let || lst) begin
        if (pend_v) emit_res(pend_l, 1'b1, 1'b0, 1'b1);
        if (held_v) emit_res(held_l, 1'b1, 1'b0, 1'b1);
        pend_v = 1'b0;
        held_v = 1'b0;
        if (is_let) emit_res(v, 1'b1, 1'b0, 1'b1);
      end
    end else begin
      if (is_let) begin
        if (held_v) begin
          p0 = mac26(inv_m[0], held_l, inv_m[1], v);
          p1 = mac26(inv_m[2], held_l, inv_m[3], v);
          if (pend_v) emit_res(pend_l, 1'b1, 1'b0, 1'b0);
          emit_res(p0, 1'b1, 1'b0, 1'b0);
          pend_l = p1;
          pend_v = 1'b1;
          held_v = 1'b0;
        end else begin
          held_l = v;
          held_v = 1'b1;
        end
      end
      if (lst) begin
        if (held_v) begin
          if (pend_v) emit_res(pend_l, 1'b1, 1'b0, 1'b0);
          emit_res(held_l, 1'b1, 1'b1, 1'b0);
        end else if (pend_v && pend_l != X_LETTER) begin
          emit_res(pend_l, 1'b1, 1'b0, 1'b0);
        end
      end
    end
    if (lst) begin
      if (step_n == 0) emit_res(5'd0, 1'b0, 1'b0, nki);
      step_buf[step_n-1].lst = 1'b1;
      held_l = '0;
      held_v = 1'b0;
      pend_l = '0;
      pend_v = 1'b0;
    end
    for (int i = 0; i < step_n; i++) cipher_out_q.push_back(step_buf[i]);
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int idle_len();
    int r;
    if (!idling) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      mismatch_cnt++;
    end
  endfunction

  // Input driver: predict on each accepted transaction, then load the next byte
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) hill_predict_byte(in_char_i, in_last_i);
      if (!in_valid_i || in_ready_o) begin
        if (in_bytes_q.size() != 0 && gap_cnt >= int'(in_bytes_q[0].gap)) begin
          drv_item   = in_bytes_q.pop_front();
          in_valid_i <= 1'b1;
          in_char_i  <= drv_item.ch;
          in_last_i  <= drv_item.lst;
          gap_cnt    = 0;
        end else begin
          in_valid_i <= 1'b0;
          if (in_bytes_q.size() != 0) gap_cnt++;
        end
      end
    end
  end

  // Result monitor with random back-pressure
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_valid_o && res_ready_i) begin
        if (cipher_out_q.size() == 0) begin
          $error("unexpected result transaction: out_char %0d", out_char_o);
          mismatch_cnt++;
        end else begin
          mon_want = cipher_out_q.pop_front();
          check_field("out_char", mon_want.ch, out_char_o);
          check_field("out_valid", mon_want.vld, out_valid_o);
          check_field("out_last", mon_want.lst, out_last_o);
          check_field("odd_length_error", mon_want.odd, odd_length_error_o);
          check_field("key_not_invertible", mon_want.nki, key_not_invertible_o);
        end
      end
      if (stall_cnt != 0) begin
        stall_cnt--;
        res_ready_i <= 1'b0;
      end else begin
        res_ready_i <= 1'b1;
        stall_cnt = idle_len();
      end
    end
  end

  task automatic cfg_write(input reg_idx_e idx, input logic [4:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= DataWidth'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    apply_cfg(idx, val);
  endtask

  task automatic send_byte(input logic [7:0] ch, input logic lst);
    byte_item_t it;
    it.ch  = ch;
    it.lst = lst;
    it.gap = 8'(idle_len());
    in_bytes_q.push_back(it);
    sent_cnt++;
  endtask

  task automatic send_text(input string s, input logic lst);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], lst && (i == s.len() - 1));
  endtask

  function automatic logic [7:0] letter_char(input logic [4:0] v);
    return ($urandom_range(0, 1) != 0) ? 8'h61 + 8'(v) : 8'h41 + 8'(v);
  endfunction

  function automatic logic [7:0] noise_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    while (is_letter_byte(b)) b = 8'($urandom_range(0, 255));
    return b;
  endfunction

  // Send the ciphertext of one plaintext pair under the current key
  task automatic send_cipher_pair(input logic [4:0] p0, input logic [4:0] p1,
                                  input logic lst);
    logic [4:0] c0, c1;
    encipher(p0, p1, c0, c1);
    send_byte(letter_char(c0), 1'b0);
    send_byte(letter_char(c1), lst);
  endtask

  // Hold the sender until every expected result is in, then let the block settle;
  // sample on the falling edge so the driver's updates have landed
  task automatic wait_idle();
    do begin
      @(negedge clk_i);
    end while (in_bytes_q.size() != 0 || in_valid_i || cipher_out_q.size() != 0 ||
               res_valid_o);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic random_message();
    logic [7:0] msg [$];
    int         kind, n;
    logic [4:0] p0, p1, c0, c1;
    kind = $urandom_range(0, 99);
    if (kind < 15) begin
      // raw bytes, broken framing
      n = $urandom_range(1, 6);
      repeat (n) msg.push_back(8'($urandom_range(0, 255)));
    end else if (dec_mode && inv_ok && kind < 75) begin
      n = $urandom_range(0, 4);
      for (int i = 0; i < n; i++) begin
        p0 = 5'($urandom_range(0, 25));
        p1 = (i == n - 1 && $urandom_range(0, 2) == 0) ? X_LETTER : 5'($urandom_range(0, 25));
        encipher(p0, p1, c0, c1);
        msg.push_back(letter_char(c0));
        if ($urandom_range(0, 7) == 0) msg.push_back(noise_byte());
        msg.push_back(letter_char(c1));
      end
      if ($urandom_range(0, 6) == 0) msg.push_back(letter_char(5'($urandom_range(0, 25))));
    end else begin
      n = $urandom_range(0, 7);
      repeat (n) begin
        if ($urandom_range(0, 6) == 0) msg.push_back(noise_byte());
        msg.push_back(letter_char(5'($urandom_range(0, 25))));
      end
    end
    if (msg.size() == 0 || $urandom_range(0, 5) == 0) msg.push_back(noise_byte());
    // drop the end mark now and then so state carries into the next message
    for (int i = 0; i < msg.size(); i++) begin
      send_byte(msg[i], (i == msg.size() - 1) && ($urandom_range(0, 19) != 0));
    end
  endtask

  function automatic logic [4:0] key_val();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 5'd0;
    if (r == 1) return 5'd25;
    return 5'($urandom_range(0, 25));
  endfunction

  initial begin
    reset_model();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // identity key, encrypt: letter extremes and bytes next to each letter range
    send_text("Az@[`{", 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte("m", 1'b1);
    send_byte(" ", 1'b1);
    wait_idle();

    idling = 1'b1;
    cfg_write(RegKeyA, 5'd3);
    cfg_write(RegKeyB, 5'd3);
    cfg_write(RegKeyC, 5'd2);
    cfg_write(RegKeyD, 5'd5);
    cfg_write(RegMode, 5'd1);
    // plaintext ends in X, which decrypt drops
    send_cipher_pair(5'd19, X_LETTER, 1'b0);
    send_cipher_pair(5'd0, X_LETTER, 1'b1);
    send_text("abC", 1'b1);
    send_text("ABC", 1'b0);
    wait_idle();

    // non-invertible key with pending and held letters left over
    cfg_write(RegKeyA, 5'd0);
    send_byte("d", 1'b1);
    send_byte(".", 1'b1);
    wait_idle();

    // pending letter left over across a switch to encrypt
    cfg_write(RegKeyA, 5'd3);
    send_text("AB", 1'b0);
    wait_idle();
    cfg_write(RegMode, 5'd0);
    send_byte("c", 1'b1);
    wait_idle();

    for (int r = 0; r < 4; r++) cfg_write(KEY_REGS[r], 5'd25);
    send_text("Zz", 1'b1);
    wait_idle();

    while (sent_cnt < 100) begin
      for (int r = 0; r < 4; r++) begin
        if ($urandom_range(0, 2) != 0) cfg_write(KEY_REGS[r], key_val());
      end
      cfg_write(RegMode, 5'($urandom_range(0, 1)));
      idling = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(2, 4)) random_message();
      wait_idle();
    end

    if (mismatch_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #(12 * 300000);
    $display("Some tests failed");
    $finish;
  end

endmodule

[hill_cipher_2x2_stream.f]
sv/hc2_pkg.sv
sv/hc2_keygen.sv
sv/hill_cipher_2x2_stream.sv
sim/tb_hill_cipher_2x2_stream.sv
